// ----- hw/rtl/bffa_pkg.sv -----
// Shared definitions for the bitmap first-fit allocator: codes, defaults and
// the command/status structs between controller and datapath.
// Depends on nothing.
package bffa_pkg;

  localparam int unsigned POOL_CELLS_DEF = 256;
  localparam int unsigned WORD_BITS_DEF  = 32;
  // Cells examined per scan cycle.
  localparam int unsigned SCAN_LANES     = 8;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned START_W  = 8;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_RESERVE  = 2'd0,
    FN_RELEASE  = 2'd1,
    FN_FREE_ALL = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_RUN    = 3'd3,
    ST_RELEASED  = 3'd4
  } status_e;

  typedef struct packed {
    logic load;
    logic clr;
    logic seek;
    logic rd;
    logic step;
    logic wb;
    logic mwr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic free_all;
    logic reserve;
    logic wlast;
    logic seek_done;
    logic found;
    logic stop;
    logic wend;
    logic mark_last;
  } sts_t;

endpackage

// ----- hw/rtl/bffa_ctrl.sv -----
// Sequencer for the bitmap allocator: one-hot state machine issuing datapath
// commands and owning both handshakes. Uses bffa_pkg.
module bffa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  bffa_pkg::sts_t  sts_i,
  output bffa_pkg::cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    S_INIT     = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_DISPATCH = 12'b0000_0000_0100,
    S_CLEAR    = 12'b0000_0000_1000,
    S_SEEK     = 12'b0000_0001_0000,
    S_RD       = 12'b0000_0010_0000,
    S_SCAN     = 12'b0000_0100_0000,
    S_FREE     = 12'b0000_1000_0000,
    S_WB       = 12'b0001_0000_0000,
    S_MRD      = 12'b0010_0000_0000,
    S_MWR      = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr = 1'b1;
        if (sts_i.wlast) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.done)          state_d = S_DONE;
        else if (sts_i.free_all) state_d = S_CLEAR;
        else if (sts_i.reserve)  state_d = S_RD;
        else                     state_d = S_SEEK;
      end
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.wlast) state_d = S_DONE;
      end
      S_SEEK: begin
        cmd_o.seek = 1'b1;
        if (sts_i.seek_done) state_d = S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = sts_i.reserve ? S_SCAN : S_FREE;
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.found)     state_d = S_MRD;
        else if (sts_i.stop) state_d = S_DONE;
        else if (sts_i.wend) state_d = S_RD;
      end
      S_FREE: begin
        cmd_o.step = 1'b1;
        if (sts_i.stop || sts_i.wend) state_d = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = sts_i.done ? S_DONE : S_RD;
      end
      S_MRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MWR;
      end
      S_MWR: begin
        cmd_o.mwr = 1'b1;
        state_d   = sts_i.mark_last ? S_DONE : S_MRD;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.emit)  out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/bffa_dp.sv -----
// Datapath of the bitmap allocator: bitmap memory, word buffer, eight-lane
// run scanner / releaser, mark masks and the result registers. Uses bffa_pkg.
module bffa_dp #(
  parameter int unsigned POOL_CELLS = bffa_pkg::POOL_CELLS_DEF,
  parameter int unsigned WORD_BITS  = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bffa_pkg::cmd_t                   cmd_i,
  output bffa_pkg::sts_t                   sts_o,
  input  logic [bffa_pkg::FUNC_W-1:0]      func_i,
  input  logic [bffa_pkg::COUNT_W-1:0]     cell_count_i,
  input  logic [bffa_pkg::START_W-1:0]     start_index_i,
  output logic [bffa_pkg::STATUS_W-1:0]    status_o,
  output logic [bffa_pkg::INDEX_W-1:0]     cell_index_o
);

  localparam int unsigned MAP_WORDS = (POOL_CELLS - 1) / WORD_BITS + 1;
  localparam int unsigned WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned CELL_W    = $clog2(POOL_CELLS + 1);
  localparam int unsigned CNT_W     = bffa_pkg::COUNT_W;
  localparam int unsigned ST_W      = bffa_pkg::START_W;
  localparam int unsigned CMP_W     = (CELL_W > CNT_W) ? CELL_W : CNT_W;
  localparam int unsigned LANES     = bffa_pkg::SCAN_LANES;

  localparam logic [ST_W-1:0]    WB_S    = ST_W'(WORD_BITS);
  localparam logic [CMP_W-1:0]   POOL_C  = CMP_W'(POOL_CELLS);
  localparam logic [CELL_W:0]    POOL_L  = (CELL_W+1)'(POOL_CELLS);
  localparam logic [BIT_W:0]     WB_L    = (BIT_W+1)'(WORD_BITS);
  localparam logic [WADDR_W-1:0] WLAST   = WADDR_W'(MAP_WORDS - 1);

  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];

  logic [WADDR_W-1:0]   wptr_q;
  logic [WORD_BITS-1:0] buf_q;
  logic [BIT_W-1:0]     boff_q;
  logic [CELL_W-1:0]    cell_q;
  logic [ST_W-1:0]      seek_q;
  logic [bffa_pkg::FUNC_W-1:0] func_q;
  logic [CNT_W-1:0]     count_q, len_q, rem_q;
  logic [CELL_W-1:0]    rs_cell_q;
  logic [WADDR_W-1:0]   rs_word_q, fe_word_q;
  logic [BIT_W-1:0]     rs_bit_q, fe_bit_q;
  bffa_pkg::status_e    res_status_q;
  logic [bffa_pkg::INDEX_W-1:0] res_index_q;
  logic                 res_done_q;
  logic [bffa_pkg::STATUS_W-1:0] out_status_q;
  logic [bffa_pkg::INDEX_W-1:0]  out_index_q;

  logic                 reserve_q;
  logic                 seek_done;
  logic                 mark_last;
  logic [WORD_BITS-1:0] mark_mask;
  logic                 we;
  logic [WORD_BITS-1:0] wdata;

  // Step results
  logic                 s_found, s_pend, s_wend, s_hole, s_ok;
  logic [CNT_W-1:0]     s_len, s_rem;
  logic [CELL_W-1:0]    s_rs_cell;
  logic [WADDR_W-1:0]   s_rs_word;
  logic [BIT_W-1:0]     s_rs_bit, s_fe_bit;
  logic [CELL_W:0]      s_ncell;
  logic [BIT_W:0]       s_nbit;
  logic [WORD_BITS-1:0] s_buf;

  assign reserve_q = (func_q == bffa_pkg::FN_RESERVE);
  assign seek_done = (seek_q < WB_S);
  assign mark_last = (wptr_q == fe_word_q);

  // Walk up to LANES cells of the current word in order, stopping at the
  // first event (run found, hole, count reached, pool or word end).
  always_comb begin
    logic go;
    logic [CELL_W:0] lcell;
    logic [BIT_W:0]  lbit;
    go        = 1'b1;
    s_found   = 1'b0;
    s_pend    = 1'b0;
    s_wend    = 1'b0;
    s_hole    = 1'b0;
    s_ok      = 1'b0;
    s_len     = len_q;
    s_rem     = rem_q;
    s_rs_cell = rs_cell_q;
    s_rs_word = rs_word_q;
    s_rs_bit  = rs_bit_q;
    s_fe_bit  = '0;
    s_ncell   = {1'b0, cell_q};
    s_nbit    = {1'b0, boff_q};
    s_buf     = buf_q;
    lcell     = '0;
    lbit      = '0;
    for (int j = 0; j < LANES; j++) begin
      lcell = {1'b0, cell_q} + (CELL_W+1)'(j);
      lbit  = {1'b0, boff_q} + (BIT_W+1)'(j);
      if (go) begin
        if (lcell >= POOL_L) begin
          s_pend = 1'b1;
          go     = 1'b0;
        end else if (lbit >= WB_L) begin
          s_wend = 1'b1;
          go     = 1'b0;
        end else begin
          s_ncell = lcell + 1'b1;
          s_nbit  = lbit + 1'b1;
          if (reserve_q) begin
            if (!buf_q[lbit[BIT_W-1:0]]) begin
              if (s_len == '0) begin
                s_rs_cell = lcell[CELL_W-1:0];
                s_rs_word = wptr_q;
                s_rs_bit  = lbit[BIT_W-1:0];
              end
              s_len = s_len + 1'b1;
              if (s_len == count_q) begin
                s_found  = 1'b1;
                s_fe_bit = lbit[BIT_W-1:0];
                go       = 1'b0;
              end
            end else begin
              s_len = '0;
            end
          end else begin
            if (!s_buf[lbit[BIT_W-1:0]]) begin
              s_hole = 1'b1;
              go     = 1'b0;
            end else begin
              s_buf[lbit[BIT_W-1:0]] = 1'b0;
              s_rem = s_rem - 1'b1;
              if (s_rem == '0) begin
                s_ok = 1'b1;
                go   = 1'b0;
              end
            end
          end
        end
      end
    end
    // Look ahead so a word or the pool ending on a lane boundary is flagged in the same step as its last lane.
    if (go) begin
      if (s_ncell >= POOL_L)    s_pend = 1'b1;
      else if (s_nbit >= WB_L)  s_wend = 1'b1;
    end
  end

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mark_mask[b] = ((wptr_q != rs_word_q) || (BIT_W'(b) >= rs_bit_q)) &&
                     ((wptr_q != fe_word_q) || (BIT_W'(b) <= fe_bit_q));
    end
  end

  assign we    = cmd_i.clr | cmd_i.mwr | cmd_i.wb;
  assign wdata = cmd_i.clr ? '0 : (cmd_i.mwr ? (buf_q | mark_mask) : buf_q);

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wptr_q] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      buf_q <= mem_q[wptr_q];
    end else if (cmd_i.step) begin
      buf_q <= s_buf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
    end else if (cmd_i.load) begin
      wptr_q <= '0;
    end else if (cmd_i.step && s_found) begin
      wptr_q <= s_rs_word;
    end else if (cmd_i.clr || cmd_i.wb || cmd_i.mwr ||
                 (cmd_i.seek && !seek_done) ||
                 (cmd_i.step && s_wend && reserve_q)) begin
      wptr_q <= wptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_done_q <= 1'b0;
    end else if (cmd_i.load) begin
      res_done_q <= 1'b0;
      unique case (func_i) inside
        bffa_pkg::FN_RESERVE, bffa_pkg::FN_RELEASE: begin
          if ((cell_count_i == '0) || (CMP_W'(cell_count_i) > POOL_C) ||
              ((func_i == bffa_pkg::FN_RELEASE) && (CMP_W'(start_index_i) >= POOL_C))) begin
            res_done_q <= 1'b1;
          end
        end
        bffa_pkg::FN_FREE_ALL: res_done_q <= 1'b0;
        default:               res_done_q <= 1'b1;
      endcase
    end else if (cmd_i.step && (s_found || s_pend || s_hole || s_ok)) begin
      res_done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q      <= func_i;
      count_q     <= cell_count_i;
      rem_q       <= cell_count_i;
      len_q       <= '0;
      seek_q      <= start_index_i;
      boff_q      <= '0;
      cell_q      <= (func_i == bffa_pkg::FN_RESERVE) ? '0 : CELL_W'(start_index_i);
      res_index_q <= '0;
      res_status_q <= bffa_pkg::ST_OK;
      if ((func_i == bffa_pkg::FN_RESERVE) || (func_i == bffa_pkg::FN_RELEASE)) begin
        if (cell_count_i == '0) begin
          res_status_q <= bffa_pkg::ST_ZERO;
        end else if ((CMP_W'(cell_count_i) > POOL_C) ||
                     ((func_i == bffa_pkg::FN_RELEASE) &&
                      (CMP_W'(start_index_i) >= POOL_C))) begin
          res_status_q <= bffa_pkg::ST_TOO_LARGE;
        end
      end
    end else begin
      if (cmd_i.seek) begin
        if (!seek_done) seek_q <= seek_q - WB_S;
        else            boff_q <= seek_q[BIT_W-1:0];
      end
      if (cmd_i.step) begin
        len_q     <= s_len;
        rem_q     <= s_rem;
        rs_cell_q <= s_rs_cell;
        rs_word_q <= s_rs_word;
        rs_bit_q  <= s_rs_bit;
        cell_q    <= s_ncell[CELL_W-1:0];
        boff_q    <= s_wend ? '0 : s_nbit[BIT_W-1:0];
        if (s_found) begin
          fe_word_q    <= wptr_q;
          fe_bit_q     <= s_fe_bit;
          res_index_q  <= bffa_pkg::INDEX_W'(s_rs_cell);
          res_status_q <= bffa_pkg::ST_OK;
        end else if (s_pend) begin
          res_status_q <= reserve_q ? bffa_pkg::ST_NO_RUN : bffa_pkg::ST_TOO_LARGE;
        end else if (s_hole) begin
          res_status_q <= bffa_pkg::ST_RELEASED;
        end else if (s_ok) begin
          res_status_q <= bffa_pkg::ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
    end
  end

  assign sts_o.done      = res_done_q;
  assign sts_o.free_all  = (func_q == bffa_pkg::FN_FREE_ALL);
  assign sts_o.reserve   = reserve_q;
  assign sts_o.wlast     = (wptr_q == WLAST);
  assign sts_o.seek_done = seek_done;
  assign sts_o.found     = s_found;
  assign sts_o.stop      = s_pend | s_hole | s_ok;
  assign sts_o.wend      = s_wend;
  assign sts_o.mark_last = mark_last;

  assign status_o     = out_status_q;
  assign cell_index_o = out_index_q;

endmodule

// ----- hw/rtl/bitmap_first_fit_allocator_core.sv -----
// Top level of the bitmap first-fit contiguous cell allocator.
// Instantiates bffa_ctrl and bffa_dp; parameters default from bffa_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | to core   | in_valid_i / in_ready_o | func_i, cell_count_i, start_index_i
//  out     | from core | out_valid_o/out_ready_i | status_o, cell_index_o
//
// One request at a time. A word is taken only in the idle state; the
// next one is taken once this result has moved into the output register.
// Reserve: a dispatch state, then per map word scanned a read and scan steps
// (eight cells per cycle through the run-length chain), then a read and a
// write per word marked.
// Release: a dispatch state, a seek step per word before the start word and
// one more for the start bit, then per word a read, scan steps and a write-back.
// Release-all: a dispatch state, then one clear per word. Errors found on the
// request itself go from dispatch straight to the done state. After reset the
// map is cleared one word a cycle with in_ready_o low. A stalled output holds
// its word and the core waits in its done state; the single memory port (one
// read or write a cycle) sets the per-word overhead.
module bitmap_first_fit_allocator_core #(
  parameter int unsigned POOL_CELLS = bffa_pkg::POOL_CELLS_DEF,
  parameter int unsigned WORD_BITS  = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bffa_pkg::FUNC_W-1:0]   func_i,
  input  logic [bffa_pkg::COUNT_W-1:0]  cell_count_i,
  input  logic [bffa_pkg::START_W-1:0]  start_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bffa_pkg::STATUS_W-1:0] status_o,
  output logic [bffa_pkg::INDEX_W-1:0]  cell_index_o
);

  bffa_pkg::cmd_t cmd;
  bffa_pkg::sts_t sts;

  // Sequencer: owns both handshakes, drives the datapath at most one command a cycle.
  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: bitmap memory, scan lanes and the output register.
  bffa_dp #(
    .POOL_CELLS (POOL_CELLS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .cell_count_i  (cell_count_i),
    .start_index_i (start_index_i),
    .status_o      (status_o),
    .cell_index_o  (cell_index_o)
  );

endmodule

// ----- hw/rtl/bffa_checker.sv -----
// Port-level checks for the bitmap allocator core, bound to the top level.
// Depends on bffa_pkg and bitmap_first_fit_allocator_core.
module bffa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [bffa_pkg::FUNC_W-1:0]   func_i,
  input logic [bffa_pkg::COUNT_W-1:0]  cell_count_i,
  input logic [bffa_pkg::START_W-1:0]  start_index_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bffa_pkg::STATUS_W-1:0] status_o,
  input logic [bffa_pkg::INDEX_W-1:0]  cell_index_o
);

  // One request at a time: drop ready straight after taking a word.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("core took a word while busy");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= bffa_pkg::STATUS_W'(bffa_pkg::ST_RELEASED)))
    else $error("status code out of range");

  a_index_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != bffa_pkg::STATUS_W'(bffa_pkg::ST_OK)))
      |-> (cell_index_o == '0))
    else $error("cell index not zero on failed request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(cell_index_o)))
    else $error("stalled result changed");

endmodule

bind bitmap_first_fit_allocator_core bffa_checker u_bffa_checker (.*);
